// ===== rtl/core/vn3_pkg.sv =====
// shared constants for the 3d value noise pipeline
`default_nettype none

package vn3_pkg;

  // splitmix64 finalizer multipliers
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  // lattice offsets of the y and z axes
  localparam logic [63:0] OFS_Y = 64'h0000000000093283;
  localparam logic [63:0] OFS_Z = 64'h0000000000793759;

  // low 64 bits of a 64x64 product, split into partial products of its 32-bit halves
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] hl;
    logic [31:0] lh;
  } vn3_pp_t;

endpackage

`default_nettype wire

// ===== rtl/core/vn3_mix.sv =====
// four-stage splitmix64 finalizer with a shared stall enable
`default_nettype none

module vn3_mix
  import vn3_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] v_i,
  output logic      [63:0] h_o
);

  logic [63:0] x1, x2, m1_d, m2_d;
  logic [63:0] ll1, ll2;
  logic [31:0] hl1, lh1, hl2, lh2;
  vn3_pp_t     pp1_q, pp2_q;
  logic [63:0] m1_q, h_q;

  // first multiply, partial products
  always_comb begin
    x1  = v_i ^ (v_i >> 30);
    ll1 = 64'(x1[31:0]) * 64'(MIX_C1[31:0]);
    hl1 = x1[63:32] * MIX_C1[31:0];
    lh1 = x1[31:0]  * MIX_C1[63:32];
  end

  // first multiply, recombine
  assign m1_d = pp1_q.ll + {pp1_q.hl + pp1_q.lh, 32'b0};

  // second multiply, partial products
  always_comb begin
    x2  = m1_q ^ (m1_q >> 27);
    ll2 = 64'(x2[31:0]) * 64'(MIX_C2[31:0]);
    hl2 = x2[63:32] * MIX_C2[31:0];
    lh2 = x2[31:0]  * MIX_C2[63:32];
  end

  // second multiply, recombine
  assign m2_d = pp2_q.ll + {pp2_q.hl + pp2_q.lh, 32'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp1_q <= '{ll: ll1, hl: hl1, lh: lh1};
      m1_q  <= m1_d;
      pp2_q <= '{ll: ll2, hl: hl2, lh: lh2};
      h_q   <= m2_d ^ (m2_d >> 31);
    end
  end

  assign h_o = h_q;

endmodule

`default_nettype wire

// ===== rtl/core/vn3_smooth.sv =====
// two-stage smoothstep weight t*t*(3-2t) on a fixed point fraction
`default_nettype none

module vn3_smooth #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [FRAC_BITS-1:0] t_i,
  output logic      [FRAC_BITS-1:0] s_o
);

  localparam logic [FRAC_BITS+1:0] THREE = (FRAC_BITS+2)'(3) << FRAC_BITS;

  logic [2*FRAC_BITS-1:0] sq;
  logic [FRAC_BITS-1:0]   a_q, t_q, s_q;
  logic [FRAC_BITS+1:0]   m;
  logic [2*FRAC_BITS+1:0] prod;

  // square, then scale by 3 - 2t
  assign sq   = (2*FRAC_BITS)'(t_i) * (2*FRAC_BITS)'(t_i);
  assign m    = THREE - {1'b0, t_q, 1'b0};
  assign prod = (2*FRAC_BITS+2)'(a_q) * (2*FRAC_BITS+2)'(m);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= sq[2*FRAC_BITS-1:FRAC_BITS];
      t_q <= t_i;
      s_q <= prod[2*FRAC_BITS-1:FRAC_BITS];
    end
  end

  assign s_o = s_q;

endmodule

`default_nettype wire

// ===== rtl/core/vn3_lerp.sv =====
// two-stage truncating linear blend of two fractions by a weight
`default_nettype none

module vn3_lerp #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned OUT_BITS  = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [OUT_BITS-1:0]  r0_i,
  input  wire logic [OUT_BITS-1:0]  r1_i,
  input  wire logic [FRAC_BITS-1:0] s_i,
  output logic      [OUT_BITS-1:0]  r_o
);

  localparam int unsigned PW = 32 + FRAC_BITS + 1;

  logic [63:0]          a0, a1, sum;
  logic [FRAC_BITS:0]   w0, w1;
  logic [PW-1:0]        h0_q, l0_q, h1_q, l1_q;
  logic [OUT_BITS-1:0]  r_q;

  // weights 1-s and s, operands split into 32-bit halves
  always_comb begin
    a0 = 64'(r0_i);
    a1 = 64'(r1_i);
    w1 = {1'b0, s_i};
    w0 = ((FRAC_BITS+1)'(1) << FRAC_BITS) - w1;
  end

  // recombine: high half shifted up, low half shifted down
  assign sum = (64'(h0_q) << (32 - FRAC_BITS)) + 64'(l0_q >> FRAC_BITS)
             + (64'(h1_q) << (32 - FRAC_BITS)) + 64'(l1_q >> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h0_q <= PW'(a0[63:32]) * PW'(w0);
      l0_q <= PW'(a0[31:0])  * PW'(w0);
      h1_q <= PW'(a1[63:32]) * PW'(w1);
      l1_q <= PW'(a1[31:0])  * PW'(w1);
      r_q  <= sum[OUT_BITS-1:0];
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/value_noise_3d_unit.sv =====
// top level of the 3d lattice value noise pipeline
//
//   channel | signals                                      | dir
//   --------+----------------------------------------------+-----
//   in      | in_valid_i in_ready_o coord_x/y/z_i          | in
//           | noise_seed_i                                 |
//   out     | out_valid_o out_ready_i noise_value_o        | out
//
// one word enters per cycle unless stalled. stages: one index stage, two
// finalizer passes of four stages each with a key stage between, and three
// two-stage blends. the 64-bit multiplies are cut into 32-bit partial
// products, which sets the depth. a stall freezes the whole pipeline while
// the last stage holds an untaken word. reset clears only the valid bits.
`default_nettype none

module value_noise_3d_unit
  import vn3_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned OUT_BITS  = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic signed [31:0]  coord_x_i,
  input  wire logic signed [31:0]  coord_y_i,
  input  wire logic signed [31:0]  coord_z_i,
  input  wire logic        [63:0]  noise_seed_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [OUT_BITS-1:0] noise_value_o
);

  localparam int unsigned DEPTH = 16;

  logic             en;
  logic [DEPTH-1:0] vld_q;

  // global advance: move unless the last stage holds an untaken word
  assign en         = !vld_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // lattice cell indices, floored and sign extended
  logic [63:0] cx, cy, cz;
  logic [63:0] idx_q [6];
  logic [63:0] seed_q [5];

  assign cx = {{(32+FRAC_BITS){coord_x_i[31]}}, coord_x_i[31:FRAC_BITS]};
  assign cy = {{(32+FRAC_BITS){coord_y_i[31]}}, coord_y_i[31:FRAC_BITS]};
  assign cz = {{(32+FRAC_BITS){coord_z_i[31]}}, coord_z_i[31:FRAC_BITS]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q[0] <= cx;
      idx_q[1] <= cx + 64'd1;
      idx_q[2] <= cy + OFS_Y;
      idx_q[3] <= cy + OFS_Y + 64'd1;
      idx_q[4] <= cz + OFS_Z;
      idx_q[5] <= cz + OFS_Z + 64'd1;
      seed_q[0] <= noise_seed_i;
      for (int i = 1; i < 5; i++) seed_q[i] <= seed_q[i-1];
    end
  end

  // axis hashes
  logic [63:0] ah [6];
  for (genvar g = 0; g < 6; g++) begin : g_axis
    vn3_mix u_mix (.clk_i, .en_i(en), .v_i(idx_q[g]), .h_o(ah[g]));
  end

  // corner keys, corner index = dx + 2*dy + 4*dz
  logic [63:0] key_q [8];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        key_q[c] <= seed_q[4] ^ ah[c % 2] ^ ah[2 + (c / 2) % 2] ^ ah[4 + c / 4];
      end
    end
  end

  // corner values
  logic [63:0]         ch [8];
  logic [OUT_BITS-1:0] cv [8];
  for (genvar g = 0; g < 8; g++) begin : g_corner
    vn3_mix u_mix (.clk_i, .en_i(en), .v_i(key_q[g]), .h_o(ch[g]));
    assign cv[g] = ch[g][63 -: OUT_BITS];
  end

  // smoothstep weights and their delay lines
  logic [FRAC_BITS-1:0] sx, sy, sz;
  logic [FRAC_BITS-1:0] sx_q [8];
  logic [FRAC_BITS-1:0] sy_q [10];
  logic [FRAC_BITS-1:0] sz_q [12];

  vn3_smooth #(.FRAC_BITS(FRAC_BITS)) u_smooth_x (
    .clk_i, .en_i(en), .t_i(coord_x_i[FRAC_BITS-1:0]), .s_o(sx)
  );
  vn3_smooth #(.FRAC_BITS(FRAC_BITS)) u_smooth_y (
    .clk_i, .en_i(en), .t_i(coord_y_i[FRAC_BITS-1:0]), .s_o(sy)
  );
  vn3_smooth #(.FRAC_BITS(FRAC_BITS)) u_smooth_z (
    .clk_i, .en_i(en), .t_i(coord_z_i[FRAC_BITS-1:0]), .s_o(sz)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q[0] <= sx;
      sy_q[0] <= sy;
      sz_q[0] <= sz;
      for (int i = 1; i < 8; i++)  sx_q[i] <= sx_q[i-1];
      for (int i = 1; i < 10; i++) sy_q[i] <= sy_q[i-1];
      for (int i = 1; i < 12; i++) sz_q[i] <= sz_q[i-1];
    end
  end

  // blend along x, then y, then z
  logic [OUT_BITS-1:0] yv [4];
  logic [OUT_BITS-1:0] zv [2];
  logic [OUT_BITS-1:0] res;

  for (genvar g = 0; g < 4; g++) begin : g_lx
    vn3_lerp #(.FRAC_BITS(FRAC_BITS), .OUT_BITS(OUT_BITS)) u_lerp (
      .clk_i, .en_i(en), .r0_i(cv[2*g]), .r1_i(cv[2*g+1]), .s_i(sx_q[7]), .r_o(yv[g])
    );
  end

  for (genvar g = 0; g < 2; g++) begin : g_ly
    vn3_lerp #(.FRAC_BITS(FRAC_BITS), .OUT_BITS(OUT_BITS)) u_lerp (
      .clk_i, .en_i(en), .r0_i(yv[2*g]), .r1_i(yv[2*g+1]), .s_i(sy_q[9]), .r_o(zv[g])
    );
  end

  vn3_lerp #(.FRAC_BITS(FRAC_BITS), .OUT_BITS(OUT_BITS)) u_lerp_z (
    .clk_i, .en_i(en), .r0_i(zv[0]), .r1_i(zv[1]), .s_i(sz_q[11]), .r_o(res)
  );

  assign out_valid_o   = vld_q[DEPTH-1];
  assign noise_value_o = res;

endmodule

`default_nettype wire
